// ----- hw/rtl/event_word_decode_time_window_macros.svh -----
// ----------------------------------------------------------------------------
// Event word decoder assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EVENT_WORD_DECODE_TIME_WINDOW_MACROS_SVH
`define EVENT_WORD_DECODE_TIME_WINDOW_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that is held off while reset is asserted.
`define EWDTW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("event word decoder check failed");

// Check that must also hold while reset is asserted.
`define EWDTW_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("event word decoder invariant failed");

`else

`define EWDTW_ASSERT(lbl, prop)
`define EWDTW_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- hw/rtl/ewdtw_pkg.sv -----
// ----------------------------------------------------------------------------
// Event word decoder package
// Field defaults, wrap constants, status codes and coordinate modulo helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ewdtw_pkg;

	// Default field positions inside an event word.
	localparam int TIME_POS   = 20;
	localparam int TIME_BITS  = 12;
	localparam int HALF_POS   = 19;
	localparam int POL_POS    = 18;
	localparam int ROW_POS    = 9;
	localparam int COORD_BITS = 9;

	localparam int WORD_W   = 32;
	localparam int TS_W     = 32;
	localparam int RAW_W    = 12;
	localparam int X_W      = 10;
	localparam int Y_W      = 9;
	localparam int SUM_W    = 11;
	localparam int WRAP_W   = 22;
	localparam int WRAP_SH  = 11;   // one wrap step is 2048 ticks
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 32;

	localparam logic [WRAP_W-1:0] WRAP_LIMIT = WRAP_W'(2097000);
	localparam logic [TS_W-1:0]   WRAP_STEP  = TS_W'(1) << WRAP_SH;

	localparam logic [CFG_W-1:0] WIN_START_RST = '0;
	localparam logic [CFG_W-1:0] WIN_END_RST   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_START = 1'b0,
		REG_WIN_END   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_EVENT  = 2'd0,
		ST_DUP    = 2'd1,
		ST_BEFORE = 2'd2,
		ST_END    = 2'd3
	} status_t;

	// Column modulo 320; input stays below 1280.
	function automatic logic [SUM_W-1:0] mod320(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		if (v >= SUM_W'(960))
			r = v - SUM_W'(960);
		else if (v >= SUM_W'(640))
			r = v - SUM_W'(640);
		else if (v >= SUM_W'(320))
			r = v - SUM_W'(320);
		else
			r = v;
		return r;
	endfunction

	// Modulo 640; input stays below 1920.
	function automatic logic [SUM_W-1:0] mod640(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		if (v >= SUM_W'(1280))
			r = v - SUM_W'(1280);
		else if (v >= SUM_W'(640))
			r = v - SUM_W'(640);
		else
			r = v;
		return r;
	endfunction

	// Row modulo 480; input stays below 1440.
	function automatic logic [SUM_W-1:0] mod480(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		if (v >= SUM_W'(960))
			r = v - SUM_W'(960);
		else if (v >= SUM_W'(480))
			r = v - SUM_W'(480);
		else
			r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/event_word_decode_time_window.sv -----
// Event word decoder with timestamp extension and time window. Takes one
// 32-bit event word per cycle while the output side is not stalled and
// returns one result word per input through the input and result registers.
// The input register feeds a single pass that extends the raw time with the
// wrap counter, classifies the word against the window and decodes x, y and
// polarity; the wrap counter, previous time and duplicate fingerprint close
// their loop within that single pass, which is what sets the rate of one
// word per cycle. A window-end result does not consume the word logically:
// the sender presents it again for the next window.
// ----------------------------------------------------------------------------
// Event word decoder, time window top level
// Input register, decode and timestamp extension pass, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "event_word_decode_time_window_macros.svh"

module event_word_decode_time_window #(
	parameter int TIME_POS   = ewdtw_pkg::TIME_POS,
	parameter int TIME_BITS  = ewdtw_pkg::TIME_BITS,
	parameter int HALF_POS   = ewdtw_pkg::HALF_POS,
	parameter int POL_POS    = ewdtw_pkg::POL_POS,
	parameter int ROW_POS    = ewdtw_pkg::ROW_POS,
	parameter int COORD_BITS = ewdtw_pkg::COORD_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write port.
	input  wire logic                             wr_en,
	input  wire logic [ewdtw_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [ewdtw_pkg::CFG_W-1:0]      wr_data,
	// Event words in.
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [31:0]                      s_tdata,   // [31:0] event_word
	input  wire logic [0:0]                       s_tuser,   // [0] new_chunk
	// Decoded results out.
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [9:0] x_coord, [18:10] y_coord, [50:19] timestamp, [51] polarity,
	// [63:52] raw_time
	output logic [63:0]                           m_tdata,
	output logic [1:0]                            m_tuser    // [1:0] status
);

	localparam int SUM_W  = ewdtw_pkg::SUM_W;
	localparam int TS_W   = ewdtw_pkg::TS_W;
	localparam int WRAP_W = ewdtw_pkg::WRAP_W;

	// Configuration and time state.
	logic [ewdtw_pkg::CFG_W-1:0] win_start_q, win_end_q;
	logic [WRAP_W-1:0]           wrap_q;
	logic [TS_W-1:0]             prev_q;
	logic                        start_clr_q;
	logic [SUM_W-1:0]            fp_q;

	// Input register.
	logic                        vld_s1;
	logic [31:0]                 word_s1;
	logic                        chunk_s1;

	// Result register.
	logic                        vld_s2;
	ewdtw_pkg::status_t          status_s2;
	logic [ewdtw_pkg::X_W-1:0]   x_s2;
	logic [ewdtw_pkg::Y_W-1:0]   y_s2;
	logic [TS_W-1:0]             ts_s2;
	logic                        pol_s2;
	logic [ewdtw_pkg::RAW_W-1:0] raw_s2;

	logic advance, load_s1;

	// Decode pass.
	logic [31:0]            raw_ext, row_ext;
	logic [TIME_BITS-1:0]   raw_f;
	logic [TS_W-1:0]        t_base, t_wrap, t_fin;
	logic                   stepped;
	logic [WRAP_W-1:0]      wrap_inc, wrap_nxt;
	logic                   hit_limit, clr_nxt;
	logic [TS_W-1:0]        eff_start;
	logic [COORD_BITS-1:0]  col_f, row_f;
	logic [SUM_W-1:0]       x_val, y_val, sum_xy, fp_eff, fp_nxt;
	ewdtw_pkg::status_t     status_nxt;

	function automatic logic [31:0] s_tdata_s1_shift(input logic [31:0] w);
		return w >> TIME_POS;
	endfunction

	assign advance  = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || advance;
	assign load_s1  = s_tvalid && s_tready;

	always_comb begin
		raw_ext  = s_tdata_s1_shift(word_s1);
		raw_f    = raw_ext[TIME_BITS-1:0];
		t_base   = TS_W'({wrap_q, {ewdtw_pkg::WRAP_SH{1'b0}}}) + TS_W'(raw_f >> 1);
		stepped  = t_base < prev_q;
		wrap_inc = wrap_q + WRAP_W'(1);
		wrap_nxt = stepped ? wrap_inc : wrap_q;
		t_wrap   = stepped ? t_base + ewdtw_pkg::WRAP_STEP : t_base;
		hit_limit = wrap_nxt >= ewdtw_pkg::WRAP_LIMIT;
		t_fin    = hit_limit ? '0 : t_wrap;
		clr_nxt  = hit_limit || start_clr_q;
		eff_start = clr_nxt ? '0 : win_start_q;

		row_ext = word_s1 >> ROW_POS;
		row_f   = row_ext[COORD_BITS-1:0];
		col_f   = word_s1[COORD_BITS-1:0];
		y_val   = ewdtw_pkg::mod480(SUM_W'(row_f));
		if (word_s1[HALF_POS])
			x_val = ewdtw_pkg::mod640(SUM_W'(col_f) + SUM_W'(320));
		else
			x_val = ewdtw_pkg::mod320(SUM_W'(col_f));
		sum_xy = x_val + y_val;

		// A new chunk clears the fingerprint before this word is checked.
		fp_eff = chunk_s1 ? '0 : fp_q;
		fp_nxt = fp_eff;
		if (t_fin < eff_start) begin
			status_nxt = ewdtw_pkg::ST_BEFORE;
		end else if (t_fin >= win_end_q) begin
			status_nxt = ewdtw_pkg::ST_END;
		end else if (sum_xy == fp_eff) begin
			status_nxt = ewdtw_pkg::ST_DUP;
		end else begin
			status_nxt = ewdtw_pkg::ST_EVENT;
			fp_nxt = sum_xy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= ewdtw_pkg::WIN_START_RST;
			win_end_q   <= ewdtw_pkg::WIN_END_RST;
			wrap_q      <= '0;
			prev_q      <= '0;
			start_clr_q <= 1'b0;
			fp_q        <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					ewdtw_pkg::REG_WIN_START: begin
						win_start_q <= wr_data;
						start_clr_q <= 1'b0;
					end
					ewdtw_pkg::REG_WIN_END: win_end_q <= wr_data;
					default: ;
				endcase
			end
			if (s_tready)
				vld_s1 <= s_tvalid;
			if (advance) begin
				vld_s2 <= vld_s1;
				if (vld_s1) begin
					wrap_q      <= hit_limit ? '0 : wrap_nxt;
					prev_q      <= t_fin;
					start_clr_q <= clr_nxt;
					fp_q        <= fp_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1  <= s_tdata;
			chunk_s1 <= s_tuser[0];
		end
		if (advance && vld_s1) begin
			status_s2 <= status_nxt;
			ts_s2     <= t_fin;
			raw_s2    <= ewdtw_pkg::RAW_W'(raw_f);
			if (status_nxt == ewdtw_pkg::ST_EVENT || status_nxt == ewdtw_pkg::ST_DUP) begin
				x_s2   <= ewdtw_pkg::X_W'(x_val);
				y_s2   <= ewdtw_pkg::Y_W'(y_val);
				pol_s2 <= word_s1[POL_POS];
			end else begin
				x_s2   <= '0;
				y_s2   <= '0;
				pol_s2 <= 1'b0;
			end
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {raw_s2, pol_s2, ts_s2, y_s2, x_s2};

	// The wrap counter is folded back to zero as soon as it reaches the limit.
	`EWDTW_ASSERT(a_wrap_below_limit, wrap_q < ewdtw_pkg::WRAP_LIMIT)

	// A delivered event leaves its own x + y as the chunk fingerprint.
	`EWDTW_ASSERT(a_event_sets_fp,
		(vld_s2 && status_s2 == ewdtw_pkg::ST_EVENT) |->
		(fp_q == SUM_W'(x_s2) + SUM_W'(y_s2)))

	// Words outside the window carry no coordinates.
	`EWDTW_ASSERT(a_outside_blank,
		(vld_s2 && (status_s2 == ewdtw_pkg::ST_BEFORE || status_s2 == ewdtw_pkg::ST_END))
		|-> (x_s2 == '0 && y_s2 == '0 && !pol_s2))

	// Hitting the wrap limit shows up as a zero timestamp on the result.
	`EWDTW_ASSERT(a_limit_clears_time,
		$rose(start_clr_q) |-> (vld_s2 && ts_s2 == '0 && prev_q == '0))

endmodule

`default_nettype wire
